/* hdl/bmp24_frame_stream_encoder_macros.svh */
// ----------------------------------------------------------------------------
// BMP stream encoder assertion macros
// Clocked on clk and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef BMP24_FRAME_STREAM_ENCODER_MACROS_SVH
`define BMP24_FRAME_STREAM_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMPENC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmpenc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BMPENC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmpenc assertion failed");

`endif

/* hdl/bmpenc_pkg.sv */
// ----------------------------------------------------------------------------
// BMP stream encoder package
// Shared constants, register indexes and the queued item type.
// ----------------------------------------------------------------------------
package bmpenc_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAY_MODE    = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

  localparam int HDR_BYTES      = 54;
  localparam int INFO_BYTES     = 40;
  localparam int BITS_PER_PIXEL = 24;
  localparam int PELS_PER_METRE = 2835;

  // Byte position within the bytes that one item causes (header, BGR, pad).
  localparam int POS_W = 6;

  // Two-entry queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // One classified pixel, with everything the back needs to serialise it.
  typedef struct packed {
    logic        hdr;        // header goes out before this pixel
    logic        eof;        // last pixel of the frame
    logic [1:0]  pad;        // zero bytes after this pixel
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] width;      // clamped frame width for the header
    logic [15:0] height;     // clamped frame height for the header
    logic [31:0] pix_bytes;  // padded pixel array size, low 32 bits
  } item_t;

endpackage

/* hdl/bmpenc_front.sv */
// ----------------------------------------------------------------------------
// BMP stream encoder front
// Holds the configuration, accepts pixels and tracks row and frame position.
// ----------------------------------------------------------------------------
module bmpenc_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [bmpenc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bmpenc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          pixel_blue_or_gray,
  input  logic [7:0]                          pixel_green,
  input  logic [7:0]                          pixel_red,
  input  logic                                q_full,
  output logic                                q_push,
  output bmpenc_pkg::item_t                   q_item
);
  import bmpenc_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RH  = $clog2(MAX_HEIGHT + 1);
  localparam int RBW = $clog2(3 * MAX_WIDTH + 4);
  localparam int PW  = RBW + RH;

  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic                  gray_mode;
  logic                  header_done;
  logic [CW-1:0]         column_count;
  logic [RH-1:0]         row_count;

  logic [CW-1:0]  w_c;
  logic [RH-1:0]  h_c;
  logic [RBW-1:0] three_w;
  logic [RBW-1:0] row_bytes;
  logic [PW-1:0]  pix_full;
  logic [CW:0]    col_inc;
  logic [RH:0]    row_inc;
  logic           row_end;
  logic           frame_end;

  // Zero acts as one, and sizes above the limit are held at the limit.
  always_comb begin
    if (frame_width == '0) begin
      w_c = CW'(1);
    end else if (17'(frame_width) > 17'(MAX_WIDTH)) begin
      w_c = CW'(MAX_WIDTH);
    end else begin
      w_c = CW'(frame_width);
    end
    if (frame_height == '0) begin
      h_c = RH'(1);
    end else if (17'(frame_height) > 17'(MAX_HEIGHT)) begin
      h_c = RH'(MAX_HEIGHT);
    end else begin
      h_c = RH'(frame_height);
    end
  end

  assign three_w   = (RBW'(w_c) << 1) + RBW'(w_c);
  assign row_bytes = (three_w + RBW'(3)) & ~RBW'(3);
  assign pix_full  = PW'(row_bytes) * PW'(h_c);

  assign col_inc   = {1'b0, column_count} + (CW+1)'(1);
  assign row_inc   = {1'b0, row_count} + (RH+1)'(1);
  assign row_end   = col_inc >= {1'b0, w_c};
  assign frame_end = row_end && (row_inc >= {1'b0, h_c});

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.hdr       = !header_done;
    q_item.eof       = frame_end;
    q_item.pad       = row_end ? 2'(row_bytes - three_w) : 2'd0;
    q_item.blue      = pixel_blue_or_gray;
    q_item.green     = gray_mode ? pixel_blue_or_gray : pixel_green;
    q_item.red       = gray_mode ? pixel_blue_or_gray : pixel_red;
    q_item.width     = 16'(w_c);
    q_item.height    = 16'(h_c);
    q_item.pix_bytes = 32'(pix_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
      gray_mode    <= 1'b1;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_GRAY_MODE:    gray_mode    <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_done  <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
    end else if (q_push) begin
      header_done <= !frame_end;
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : RH'(row_inc);
      end else begin
        column_count <= CW'(col_inc);
      end
    end
  end

endmodule

/* hdl/bmpenc_queue.sv */
// ----------------------------------------------------------------------------
// BMP stream encoder queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module bmpenc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bmpenc_pkg::item_t push_item,
  input  logic              pop,
  output bmpenc_pkg::item_t head,
  output logic              empty,
  output logic              full
);
  import bmpenc_pkg::*;

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign empty = count == '0;
  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

/* hdl/bmpenc_back.sv */
// ----------------------------------------------------------------------------
// BMP stream encoder back
// Serialises the head into header, pixel and pad bytes, one a cycle at most.
// ----------------------------------------------------------------------------
module bmpenc_back (
  input  logic              clk,
  input  logic              rst,
  input  bmpenc_pkg::item_t head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              end_of_item,
  output logic              end_of_frame
);
  import bmpenc_pkg::*;

  localparam logic [POS_W-1:0] PIX_POS = POS_W'(HDR_BYTES);

  logic             started;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] cur_pos;
  logic [POS_W-1:0] last_pos;
  logic             load;
  logic             is_last;
  logic [7:0]       byte_sel;

  function automatic logic [7:0] header_byte(input logic [POS_W-1:0] idx,
                                             input item_t it);
    logic [31:0]      field;
    logic [POS_W-1:0] sel;
    logic [7:0]       hb;
    // Every 32-bit field of the header starts two bytes past a word boundary.
    sel   = idx - POS_W'(2);
    field = 32'd0;
    case (idx) inside
      [6'd2:6'd5]:   field = it.pix_bytes + 32'(HDR_BYTES);
      [6'd10:6'd13]: field = 32'(HDR_BYTES);
      [6'd14:6'd17]: field = 32'(INFO_BYTES);
      [6'd18:6'd21]: field = 32'(it.width);
      [6'd22:6'd25]: field = 32'd0 - 32'(it.height);
      [6'd34:6'd37]: field = it.pix_bytes;
      [6'd38:6'd45]: field = 32'(PELS_PER_METRE);
      default:       field = 32'd0;
    endcase
    hb = field[{sel[1:0], 3'b000} +: 8];
    case (idx)
      6'd0:    hb = 8'h42;
      6'd1:    hb = 8'h4D;
      6'd26:   hb = 8'd1;
      6'd28:   hb = 8'(BITS_PER_PIXEL);
      default: ;
    endcase
    return hb;
  endfunction

  assign cur_pos  = started ? pos : (head.hdr ? '0 : PIX_POS);
  assign last_pos = PIX_POS + POS_W'(2) + POS_W'(head.pad);
  assign is_last  = cur_pos == last_pos;
  assign load     = !q_empty && (!out_valid || out_ready);
  assign q_pop    = load && is_last;

  always_comb begin
    if (cur_pos < PIX_POS) begin
      byte_sel = header_byte(cur_pos, head);
    end else if (cur_pos == PIX_POS) begin
      byte_sel = head.blue;
    end else if (cur_pos == PIX_POS + POS_W'(1)) begin
      byte_sel = head.green;
    end else if (cur_pos == PIX_POS + POS_W'(2)) begin
      byte_sel = head.red;
    end else begin
      byte_sel = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= byte_sel;
      end_of_item  <= is_last;
      end_of_frame <= is_last && head.eof;
      pos          <= cur_pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      started   <= !is_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/bmp24_frame_stream_encoder.sv */
// ----------------------------------------------------------------------------
// 24-bit top-down BMP frame stream encoder
// A pixel's first byte goes through the queue and the back's output register.
// Throughput: one byte a cycle while out_ready is high and bytes are due; a
// pixel gives its BGR bytes, its pad bytes and any header first.
// Reset (rst, synchronous): queue empty, output idle, new frame with header.
// ----------------------------------------------------------------------------
module bmp24_frame_stream_encoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [bmpenc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bmpenc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         pixel_blue_or_gray,
  input  logic [7:0]                         pixel_green,
  input  logic [7:0]                         pixel_red,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  output logic                               end_of_item,
  output logic                               end_of_frame
);
  import bmpenc_pkg::*;

  // The front owns the configuration and the row, column and header state.
  // It classifies each pixel as it is accepted: whether the header goes out
  // first, how many pad bytes close its row and whether it ends the frame.
  // The header's size fields are worked out there too, so that an item in
  // the queue is complete on its own.
  item_t q_in_item;
  item_t q_head;
  logic  q_push;
  logic  q_pop;
  logic  q_empty;
  logic  q_full;

  bmpenc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .cfg_wen            (cfg_wen),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .pixel_blue_or_gray (pixel_blue_or_gray),
    .pixel_green        (pixel_green),
    .pixel_red          (pixel_red),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_item             (q_in_item)
  );

  // Two entries let the front take the next pixel while the back is still
  // spelling out the current one, so a pixel may follow in the next cycle.
  bmpenc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // The back walks the head item byte by byte and pops it with its last
  // byte. The output register parts it from the downstream stall.
  bmpenc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .end_of_item  (end_of_item),
    .end_of_frame (end_of_frame)
  );

endmodule

/* hdl/bmpenc_checker.sv */
// ----------------------------------------------------------------------------
// BMP stream encoder checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "bmp24_frame_stream_encoder_macros.svh"

module bmpenc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       end_of_item,
  input logic       end_of_frame
);

  // Items accepted whose last byte has not yet been taken.
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + 3'(in_valid && in_ready)
                 - 3'(out_valid && out_ready && end_of_item);
    end
  end

  `BMPENC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(end_of_item) && $stable(end_of_frame))
  `BMPENC_ASSERT_NOW(a_frame_end_closes_item, out_valid && end_of_frame, end_of_item)
  `BMPENC_ASSERT_NOW(a_item_end_has_owner, out_valid && out_ready && end_of_item, pending != 3'd0)
  `BMPENC_ASSERT_NOW(a_pending_bound, in_valid || out_valid || !in_valid, pending <= 3'd3)

endmodule

bind bmp24_frame_stream_encoder bmpenc_checker u_bmpenc_checker (.*);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the 24-bit top-down BMP frame stream encoder
// Sends pixels through the valid/ready input and checks every output byte.
// The bytes are checked against an in-bench encoder that keeps its own frame
// counters and register copies. A short directed table comes first, then
// random frame shapes, with random idling and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import bmpenc_pkg::*;

  localparam int MAX_W         = 4096;
  localparam int MAX_H         = 4096;
  localparam int CFG_MAX       = (1 << CFG_DATA_W) - 1;
  localparam int PIXEL_BYTES   = 3;
  localparam int RANDOM_PIXELS = 160;
  localparam int HOLD_CYCLES   = 500;
  localparam int HOLD_AFTER    = 80;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;  // "BM", low byte first

  // One expected byte of the BMP stream.
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       eof;
  } bmp_byte_t;

  // One row of the directed table: a register write or a pixel.
  typedef enum logic [1:0] {SET_WIDTH, SET_HEIGHT, SET_GRAY, PIXEL} step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    logic [12:0] value;      // register data for the write rows
    logic [23:0] bgr;        // pixel, blue in the top byte
    logic        typed;      // expected bytes below are given by hand
    logic [23:0] typed_bgr;
    logic [1:0]  typed_pad;
    logic        typed_eof;
  } step_t;

  localparam int N_DIR = 36;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             pixel_blue_or_gray;
  logic [7:0]             pixel_green;
  logic [7:0]             pixel_red;
  logic                   out_valid;
  logic                   out_ready;
  logic [7:0]             out_byte;
  logic                   end_of_item;
  logic                   end_of_frame;

  // Predictor state: register copies and frame position.
  logic [CFG_DATA_W-1:0] width_set  = RESET_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] height_set = RESET_FRAME_HEIGHT;
  logic                  gray_set   = 1'b1;
  int unsigned           col_cnt    = 0;
  int unsigned           row_cnt    = 0;
  bit                    hdr_sent   = 1'b0;

  bmp_byte_t bytes_due [$];

  int errors          = 0;
  int pixels_accepted = 0;
  int reg_writes      = 0;
  int headers_due     = 0;
  int bytes_checked   = 0;
  int frames_closed   = 0;
  int burst_left      = 0;
  int cycle_count     = 0;
  int stall_run       = 0;
  int stall_longest   = 0;

  // Directed table. Typed rows carry the pixel bytes, the pad count and the
  // frame end by hand; any header in front of them still comes from the
  // predictor, as do the untyped rows in full.
  step_t directed_steps [N_DIR] = '{
    // Reset state, 640 x 480 gray: green and red must be ignored.
    '{PIXEL,      13'd0,    24'h00FFFF, 1'b1, 24'h000000, 2'd0, 1'b0},
    '{SET_WIDTH,  13'd1,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{SET_HEIGHT, 13'd1,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{SET_GRAY,   13'd0,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    // Width shrunk below the current column: row and frame close at once.
    '{PIXEL,      13'd0,    24'hFF0080, 1'b1, 24'hFF0080, 2'd1, 1'b1},
    // One-pixel frame: header, BGR, one pad byte.
    '{PIXEL,      13'd0,    24'h00FF7F, 1'b1, 24'h00FF7F, 2'd1, 1'b1},
    '{SET_WIDTH,  13'd2,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'h55AA01, 1'b1, 24'h55AA01, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'hAA55FE, 1'b1, 24'hAA55FE, 2'd2, 1'b1},
    // Three pixels per row pad by three; two rows, gray.
    '{SET_WIDTH,  13'd3,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{SET_HEIGHT, 13'd2,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{SET_GRAY,   13'd1,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'h0180FF, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'h7F0000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'hFE1234, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'h02ABCD, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'h40EEEE, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'hBF0101, 1'b0, 24'h000000, 2'd0, 1'b0},
    // Zero sizes behave as one.
    '{SET_WIDTH,  13'd0,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{SET_HEIGHT, 13'd0,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'hC35A5A, 1'b1, 24'hC3C3C3, 2'd1, 1'b1},
    '{PIXEL,      13'd0,    24'h3CFFFF, 1'b1, 24'h3C3C3C, 2'd1, 1'b1},
    // Oversized width clamps to the maximum; height at the maximum.
    '{SET_WIDTH,  13'd8191, 24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{SET_HEIGHT, 13'd4096, 24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{SET_GRAY,   13'd0,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'h123456, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{SET_WIDTH,  13'd4096, 24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'hFFFFFF, 1'b0, 24'h000000, 2'd0, 1'b0},
    // Shrink mid-row to four, then cut the frame to one row mid-frame.
    '{SET_WIDTH,  13'd4,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'h808080, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{SET_HEIGHT, 13'd1,    24'h000000, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'h0F1E2D, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'hF0E1D2, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'h7FFF00, 1'b0, 24'h000000, 2'd0, 1'b0},
    '{PIXEL,      13'd0,    24'h00FF7F, 1'b0, 24'h000000, 2'd0, 1'b0}
  };

  bmp24_frame_stream_encoder #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_wen            (cfg_wen),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .pixel_blue_or_gray (pixel_blue_or_gray),
    .pixel_green        (pixel_green),
    .pixel_red          (pixel_red),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .end_of_item        (end_of_item),
    .end_of_frame       (end_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Reset is held from the start and released on a falling edge.
  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // Encodes one accepted pixel. Any header goes straight onto the queue of
  // due bytes; the pixel bytes and row padding are handed back so that a
  // typed table row can stand in for them.
  function automatic void encode_pixel(input logic [23:0] bgr, output bmp_byte_t tail [$]);
    int unsigned wc;
    int unsigned hc;
    int unsigned row_bytes;
    int unsigned pad;
    logic [31:0] pix;
    logic [7:0]  hd [0:HDR_BYTES-1];
    logic [7:0]  b;
    logic [7:0]  g;
    logic [7:0]  r;
    bit          frame_done;

    wc = (width_set == 0) ? 1 : ((width_set > MAX_W) ? MAX_W : width_set);
    hc = (height_set == 0) ? 1 : ((height_set > MAX_H) ? MAX_H : height_set);
    row_bytes = (wc * PIXEL_BYTES + 3) & ~32'd3;
    pad = row_bytes - wc * PIXEL_BYTES;
    frame_done = 1'b0;

    if (!hdr_sent) begin
      pix = row_bytes * hc;
      for (int i = 0; i < HDR_BYTES; i++) hd[i] = 8'h00;
      {hd[1], hd[0]}                = BMP_SIGNATURE;
      {hd[5], hd[4], hd[3], hd[2]}     = pix + HDR_BYTES;
      {hd[13], hd[12], hd[11], hd[10]} = HDR_BYTES;
      {hd[17], hd[16], hd[15], hd[14]} = INFO_BYTES;
      {hd[21], hd[20], hd[19], hd[18]} = wc;
      // Negative height marks the rows as stored top-down.
      {hd[25], hd[24], hd[23], hd[22]} = 32'd0 - hc;
      hd[26] = 8'd1;
      hd[28] = 8'(BITS_PER_PIXEL);
      {hd[37], hd[36], hd[35], hd[34]} = pix;
      {hd[41], hd[40], hd[39], hd[38]} = PELS_PER_METRE;
      {hd[45], hd[44], hd[43], hd[42]} = PELS_PER_METRE;
      for (int i = 0; i < HDR_BYTES; i++) bytes_due.push_back(bmp_byte_t'{hd[i], 1'b0, 1'b0});
      hdr_sent = 1'b1;
      headers_due++;
    end

    b = bgr[23:16];
    g = gray_set ? b : bgr[15:8];
    r = gray_set ? b : bgr[7:0];
    tail = {};
    tail.push_back(bmp_byte_t'{b, 1'b0, 1'b0});
    tail.push_back(bmp_byte_t'{g, 1'b0, 1'b0});
    tail.push_back(bmp_byte_t'{r, 1'b0, 1'b0});

    // A count already past a shrunken size closes the row or frame at once.
    col_cnt++;
    if (col_cnt >= wc) begin
      repeat (pad) tail.push_back(bmp_byte_t'{8'h00, 1'b0, 1'b0});
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= hc) begin
        row_cnt = 0;
        hdr_sent = 1'b0;
        frame_done = 1'b1;
      end
    end
    tail[tail.size()-1].eoi = 1'b1;
    tail[tail.size()-1].eof = frame_done;
  endfunction

  // Offers one pixel and returns at the rising edge that accepts it. The
  // sender works in bursts; between bursts valid drops for a random idle gap.
  task automatic offer_pixel(input logic [23:0] bgr);
    int idle;
    if (burst_left == 0) begin
      idle = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      @(negedge clk) in_valid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    pixel_blue_or_gray <= bgr[23:16];
    pixel_green        <= bgr[15:8];
    pixel_red          <= bgr[7:0];
    do @(posedge clk); while (!in_ready);
    burst_left--;
    pixels_accepted++;
  endtask

  // Stops offering and waits until every due byte has come out, so that
  // the registers can be written while the block is idle.
  task automatic settle_stream();
    @(negedge clk) in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk) cfg_wen <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  width_set = val;
      REG_FRAME_HEIGHT: height_set = val;
      REG_GRAY_MODE:    gray_set = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Main stimulus: the directed table, then random frame shapes.
  initial begin
    bmp_byte_t   tail [$];
    step_t       row;
    logic [23:0] bgr;
    int          shape;
    int          new_w;
    int          new_h;
    int          n_pix;
    int          random_pixels;

    cfg_wen            = 1'b0;
    cfg_index          = REG_FRAME_WIDTH;
    cfg_data           = '0;
    in_valid           = 1'b0;
    pixel_blue_or_gray = 8'h00;
    pixel_green        = 8'h00;
    pixel_red          = 8'h00;
    random_pixels      = 0;
    wait (rst === 1'b0);

    for (int k = 0; k < N_DIR; k++) begin
      row = directed_steps[k];
      case (row.kind)
        SET_WIDTH: begin
          settle_stream();
          write_reg(REG_FRAME_WIDTH, row.value);
        end
        SET_HEIGHT: begin
          settle_stream();
          write_reg(REG_FRAME_HEIGHT, row.value);
        end
        SET_GRAY: begin
          settle_stream();
          write_reg(REG_GRAY_MODE, row.value);
        end
        default: begin
          offer_pixel(row.bgr);
          encode_pixel(row.bgr, tail);
          if (row.typed) begin
            tail = {};
            for (int j = 0; j < PIXEL_BYTES; j++) begin
              tail.push_back(bmp_byte_t'{row.typed_bgr[23-8*j -: 8], 1'b0, 1'b0});
            end
            repeat (row.typed_pad) tail.push_back(bmp_byte_t'{8'h00, 1'b0, 1'b0});
            tail[tail.size()-1].eoi = 1'b1;
            tail[tail.size()-1].eof = row.typed_eof;
          end
          foreach (tail[j]) bytes_due.push_back(tail[j]);
        end
      endcase
    end

    // Random part. Mostly small frames so that headers, padding and frame
    // ends come often; now and then a zero or oversized register, with only
    // a few pixels, so that later shrinks land mid-row and mid-frame.
    while (random_pixels < RANDOM_PIXELS) begin
      shape = $urandom_range(0, 9);
      new_w = $urandom_range(1, 6);
      new_h = $urandom_range(1, 3);
      n_pix = new_w * new_h + $urandom_range(0, new_w * new_h);
      case (shape)
        7: begin
          new_w = 0;
          new_h = $urandom_range(0, 2);
          n_pix = $urandom_range(1, 4);
        end
        8: begin
          new_w = $urandom_range(MAX_W, CFG_MAX);
          n_pix = $urandom_range(1, 3);
        end
        9: begin
          new_h = $urandom_range(MAX_H, CFG_MAX);
          n_pix = $urandom_range(2, 8);
        end
        default: ;
      endcase
      settle_stream();
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(new_w));
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(new_h));
      if ($urandom_range(0, 2) == 0) write_reg(REG_GRAY_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      repeat (n_pix) begin
        bgr = 24'($urandom);
        offer_pixel(bgr);
        encode_pixel(bgr, tail);
        foreach (tail[j]) bytes_due.push_back(tail[j]);
        random_pixels++;
      end
    end

    // Drain, then give the block a little longer to show any stray byte.
    settle_stream();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d pixels (%0d directed), %0d register writes, %0d headers.",
             pixels_accepted, pixels_accepted - random_pixels, reg_writes, headers_due);
    $display("Compared %0d bytes over %0d closed frames; longest input stall %0d cycles.",
             bytes_checked, frames_closed, stall_longest);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Output side. The receiver changes its stall pattern after each random
  // span; once, well into the run, it holds off for a long stretch while
  // the sender keeps offering, so that the block fills and stalls its input.
  initial begin
    int  mode;
    int  span;
    bit  hold_done;

    out_ready = 1'b0;
    hold_done = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!hold_done && pixels_accepted >= HOLD_AFTER) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // Every accepted byte is matched against the oldest due byte.
  always @(posedge clk) begin : check_bytes
    bmp_byte_t due;
    bmp_byte_t seen;
    if (!rst && out_valid && out_ready) begin
      seen = '{out_byte, end_of_item, end_of_frame};
      bytes_checked++;
      if (bytes_due.size() == 0) begin
        errors++;
        $display("%0t: byte with nothing due: expected none, got data %02h eoi %b eof %b",
                 $time, seen.data, seen.eoi, seen.eof);
      end else begin
        due = bytes_due.pop_front();
        if (due.eof) frames_closed++;
        if (seen !== due) begin
          errors++;
          $display("%0t: expected data %02h eoi %b eof %b, got data %02h eoi %b eof %b",
                   $time, due.data, due.eoi, due.eof, seen.data, seen.eoi, seen.eof);
        end
      end
    end
  end

  // Cycle limit, and the longest run of input stall for the summary.
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && !in_ready) begin
      stall_run++;
      if (stall_run > stall_longest) stall_longest = stall_run;
    end else begin
      stall_run = 0;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bytes still due.", cycle_count,
               bytes_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
